[hw/rtl/sks_pkg.sv]
// Shared types, constants and functions of the Salsa20 keystream XOR unit.
package sks_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Input queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_NONCE    = 2'd2;

  // "expand 16-byte k"
  localparam logic [31:0] TAU0 = 32'h6170_7865;
  localparam logic [31:0] TAU1 = 32'h3120_646e;
  localparam logic [31:0] TAU2 = 32'h7962_2d36;
  localparam logic [31:0] TAU3 = 32'h6b20_6574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // One queued byte, tagged by the front with its block position and counter
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        need_block;
    logic [5:0]  pos;
    logic [31:0] counter;
  } item_t;

  // Word indexes a, b, c, d of the four quarter-rounds: [row][quarter][letter]
  localparam logic [3:0] QMAP [2][4][4] = '{
    '{ '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
       '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11} },
    '{ '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
       '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  // Left rotation of one quarter-round sub-step: 7, 9, 13, 18
  function automatic word_t qr_rot(word_t v, logic [1:0] sub);
    word_t r;
    case (sub)
      2'd0:    r = {v[24:0], v[31:25]};
      2'd1:    r = {v[22:0], v[31:23]};
      2'd2:    r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

  function automatic block_t init_block(logic [63:0] key_low, logic [63:0] key_high,
                                        logic [63:0] nonce, logic [31:0] counter);
    block_t b;
    b[0]  = TAU0;
    b[1]  = key_low[31:0];
    b[2]  = key_low[63:32];
    b[3]  = key_high[31:0];
    b[4]  = key_high[63:32];
    b[5]  = TAU1;
    b[6]  = nonce[31:0];
    b[7]  = nonce[63:32];
    b[8]  = counter;
    b[9]  = '0;
    b[10] = TAU2;
    b[11] = key_low[31:0];
    b[12] = key_low[63:32];
    b[13] = key_high[31:0];
    b[14] = key_high[63:32];
    b[15] = TAU3;
    return b;
  endfunction

endpackage

[hw/rtl/sks_if.sv]
// Stream interfaces for message bytes and result bytes.
interface sks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_out;
  modport source (output valid, output cipher_byte, output last_out, input ready);
  modport sink (input valid, input cipher_byte, input last_out, output ready);
endinterface

[hw/rtl/sks_front.sv]
// Front end: accepts message bytes, tags block position and counter.
module sks_front (
  input  logic           clk,
  input  logic           rst,
  sks_in_if.sink         message,
  output logic           push_valid,
  output sks_pkg::item_t push_item,
  input  logic           push_ready
);

  logic [5:0]  pos;
  logic [31:0] counter;
  logic [5:0]  pos_inc;
  logic        accept;

  assign message.ready = push_ready;
  assign push_valid    = message.valid;
  assign accept        = message.valid && push_ready;
  assign pos_inc       = pos + 6'd1;

  always_comb begin
    push_item.data_byte  = message.data_byte;
    push_item.last_byte  = message.last_byte;
    push_item.need_block = (pos == 6'd0);
    push_item.pos        = pos;
    push_item.counter    = counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      counter <= '0;
    end else if (accept) begin
      if (message.last_byte) begin
        pos     <= '0;
        counter <= '0;
      end else begin
        pos <= pos_inc;
        // advance the block counter on wrap to a new block
        if (pos_inc == 6'd0) counter <= counter + 32'd1;
      end
    end
  end

endmodule

[hw/rtl/sks_queue.sv]
// Short queue of tagged bytes between front and back.
module sks_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  sks_pkg::item_t push_item,
  output logic           push_ready,
  output logic           head_valid,
  output sks_pkg::item_t head_item,
  input  logic           pop
);

  sks_pkg::item_t                  mem [sks_pkg::QDEPTH];
  logic [sks_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sks_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sks_pkg::QPTR_W:0]        count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != (sks_pkg::QPTR_W + 1)'(sks_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

[hw/rtl/sks_back.sv]
// Back end: Salsa20 block core (one quarter-round sub-step per cycle) and byte XOR.
module sks_back #(
  parameter int DOUBLE_ROUNDS = sks_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sks_pkg::item_t head_item,
  output logic           pop,
  input  logic [63:0]    key_low,
  input  logic [63:0]    key_high,
  input  logic [63:0]    nonce_value,
  sks_out_if.source      result
);

  localparam int RND_W = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t            state;
  sks_pkg::block_t   w;
  sks_pkg::block_t   w_next;
  sks_pkg::block_t   ks;
  sks_pkg::block_t   init;
  logic [2:0]        step;
  logic [RND_W-1:0]  rnd;
  logic              fresh;
  logic              out_valid;
  logic [7:0]        out_byte;
  logic              out_last;
  logic              out_free;
  logic              start;
  sks_pkg::word_t    ks_word;
  logic [7:0]        ks_byte;

  assign init     = sks_pkg::init_block(key_low, key_high, nonce_value, head_item.counter);
  assign out_free = !out_valid || result.ready;
  assign pop      = (state == S_IDLE) && head_valid && (!head_item.need_block || fresh)
                    && out_free;
  assign start    = (state == S_IDLE) && head_valid && head_item.need_block && !fresh;
  assign ks_word  = ks[head_item.pos[5:2]];
  assign ks_byte  = ks_word[{head_item.pos[1:0], 3'b000} +: 8];

  assign result.valid       = out_valid;
  assign result.cipher_byte = out_byte;
  assign result.last_out    = out_last;

  // Four parallel quarter-rounds, one of their four dependent steps per cycle
  always_comb begin
    logic [1:0]     sub;
    logic [3:0]     dst;
    logic [3:0]     xs;
    logic [3:0]     ys;
    sks_pkg::word_t sum;
    w_next = w;
    sub    = step[1:0];
    for (int q = 0; q < 4; q++) begin
      dst = sks_pkg::QMAP[step[2]][q][sub + 2'd1];
      xs  = sks_pkg::QMAP[step[2]][q][sub];
      ys  = sks_pkg::QMAP[step[2]][q][sub - 2'd1];
      sum = w[xs] + w[ys];
      w_next[dst] = w[dst] ^ sks_pkg::qr_rot(sum, sub);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      rnd       <= '0;
      fresh     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            step  <= '0;
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            if (rnd == RND_W'(DOUBLE_ROUNDS - 1)) state <= S_FINAL;
            else rnd <= rnd + 1'b1;
          end
        end
        S_FINAL: begin
          fresh <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (pop) begin
        fresh     <= 1'b0;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) w <= init;
    else if (state == S_ROUND) w <= w_next;
    if (state == S_FINAL) begin
      for (int i = 0; i < 16; i++) ks[i] <= w[i] + init[i];
    end
    if (pop) begin
      out_byte <= head_item.data_byte ^ ks_byte;
      out_last <= head_item.last_byte;
    end
  end

endmodule

[hw/rtl/salsa20_keystream_xor_unit.sv]
// Top level of the Salsa20/20 128-bit-key keystream XOR unit.
// Path: inside a block, an accepted byte is stored in the queue and then in the output register;
// the first byte of each 64-byte block also waits for its keystream block to be computed
// while the shared quarter-round core runs one sub-step per cycle.
// Throughput: one byte per cycle inside a block while result.ready does not stall the output register.
// Reset: synchronous rst clears queue, position, counter, key and nonce to zero.
module salsa20_keystream_xor_unit #(
  parameter int DOUBLE_ROUNDS = sks_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sks_in_if.sink      message,
  sks_out_if.source   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]    key_low;
  logic [63:0]    key_high;
  logic [63:0]    nonce_value;
  logic           push_valid;
  logic           push_ready;
  sks_pkg::item_t push_item;
  logic           head_valid;
  sks_pkg::item_t head_item;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      nonce_value <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sks_pkg::CFG_KEY_LOW:  key_low     <= cfg_data;
        sks_pkg::CFG_KEY_HIGH: key_high    <= cfg_data;
        sks_pkg::CFG_NONCE:    nonce_value <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  sks_front u_front (
    .clk        (clk),
    .rst        (rst),
    .message    (message),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  sks_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  sks_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .key_low     (key_low),
    .key_high    (key_high),
    .nonce_value (nonce_value),
    .result      (result)
  );

endmodule

[hw/rtl/sks_checker.sv]
// Port-level checker for the keystream XOR unit, bound to the top level.
module sks_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] cipher_byte,
  input logic       last_out
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else if (in_acc && !out_acc) pending <= pending + 3'd1;
    else if (!in_acc && out_acc) pending <= pending - 3'd1;
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cipher_byte) && $stable(last_out))
    else $error("result payload changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result shown with no transaction outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more transactions outstanding than queue and output hold");

endmodule

bind salsa20_keystream_xor_unit sks_checker u_sks_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (message.valid),
  .in_ready    (message.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .cipher_byte (result.cipher_byte),
  .last_out    (result.last_out)
);
